FILE: rtl/core/wpf_pkg.sv
`default_nettype none
package wpf_pkg;

    localparam int MAX_POINTS   = 256;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int LEN_W = $clog2(MAX_POINTS + 1);
    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam int DIR_W = $clog2(CORDIC_STEPS);
    localparam int TAB_W = $clog2(TABLE_LEN);

    // CORDIC datapath: 33-bit offsets grow by the CORDIC gain
    localparam int CW = 36;
    localparam int ZW = 20;

    localparam logic signed [ZW-1:0] PI_Q     = 20'sd205887;
    localparam logic signed [16:0]   INV_GAIN = 17'sd39797;
    localparam logic [12:0]          DT_Q     = 13'd6554;
    localparam logic [15:0]          HALF_Q   = 16'd32768;
    localparam logic [39:0]          SUM_MAX  = 40'h7F_FFFF_FFFF;

    localparam int OUT_W = 152;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_VEC, ST_DIST, ST_ERR, ST_SUM, ST_MAC,
        ST_STEP, ST_MV, ST_MVS, ST_ROT, ST_UPD
    } t_state;

    typedef enum logic [2:0] {
        REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_STEP_LIM, REG_TURN_LIM, REG_ARRIVE
    } t_reg;

    typedef struct packed {
        logic                    start;
        logic                    rotate;
        logic [CORDIC_STEPS-1:0] dirs;
    } t_cor_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cor_stat;

    function automatic logic signed [ZW-1:0] atan_q(input logic [TAB_W-1:0] i);
        case (i)
            0:       atan_q = 20'sd51472;
            1:       atan_q = 20'sd30385;
            2:       atan_q = 20'sd16055;
            3:       atan_q = 20'sd8150;
            4:       atan_q = 20'sd4091;
            5:       atan_q = 20'sd2047;
            6:       atan_q = 20'sd1024;
            7:       atan_q = 20'sd512;
            8:       atan_q = 20'sd256;
            9:       atan_q = 20'sd128;
            10:      atan_q = 20'sd64;
            11:      atan_q = 20'sd32;
            12:      atan_q = 20'sd16;
            13:      atan_q = 20'sd8;
            14:      atan_q = 20'sd4;
            15:      atan_q = 20'sd2;
            16:      atan_q = 20'sd1;
            default: atan_q = '0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -40'sd2147483648)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wpf_ram.sv
`default_nettype none
module wpf_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/wpf_cordic.sv
`default_nettype none
module wpf_cordic (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire wpf_pkg::t_cor_cmd                  i_cmd,
    input  wire logic signed [wpf_pkg::CW-1:0]      i_x,
    input  wire logic signed [wpf_pkg::CW-1:0]      i_y,
    input  wire logic signed [wpf_pkg::ZW-1:0]      i_z,
    output wpf_pkg::t_cor_stat                      o_stat,
    output logic signed [wpf_pkg::CW-1:0]           o_x,
    output logic signed [wpf_pkg::CW-1:0]           o_y,
    output logic signed [wpf_pkg::ZW-1:0]           o_z,
    output logic [wpf_pkg::CORDIC_STEPS-1:0]        o_dirs
);

    logic signed [wpf_pkg::CW-1:0]    r_x, r_y, n_x, n_y, xs, ys;
    logic signed [wpf_pkg::ZW-1:0]    r_z, n_z, ang;
    logic [wpf_pkg::CORDIC_STEPS-1:0] r_dirs;
    logic [wpf_pkg::CNT_W-1:0]        r_i;
    logic                             r_busy, r_done, r_rot, d, up;

    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        ang = wpf_pkg::atan_q(wpf_pkg::TAB_W'(r_i));
        // vectoring drives y toward zero; rotation replays the recorded turns
        d   = r_rot ? r_dirs[r_i[wpf_pkg::DIR_W-1:0]] : !r_y[wpf_pkg::CW-1];
        up  = r_rot ? !d : d;
        if (up) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + ang;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == wpf_pkg::CNT_W'(wpf_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !r_busy) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
            r_rot  <= i_cmd.rotate;
            r_dirs <= i_cmd.rotate ? i_cmd.dirs : '0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            if (!r_rot) begin
                r_dirs[r_i[wpf_pkg::DIR_W-1:0]] <= d;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_dirs = r_dirs;

endmodule
`default_nettype wire

FILE: rtl/core/waypoint_pid_follower_unit.sv
`default_nettype none
// Waypoint follower with a PID loop on distance, Q16.16 throughout.
// Input stream: tuser[0] = 1 loads a path point (tdata = x, y), tuser[1]
// marks the first point of a new path. tuser[0] = 0 is a tick; a tick with
// a waypoint left produces one result item, otherwise nothing.
// Output stream: tdata carries position, heading, speed, accel and the
// target index; tlast is high when the tick finished the last waypoint.
// Gains and limits sit on the APB port; write them only while idle.
// A tick does one memory read, a CORDIC vectoring pass for distance and
// bearing, six 11-bit gain slices through one MAC, and a CORDIC rotation
// pass for the move vector; both CORDIC passes are skipped when the
// offset to the waypoint is zero.
// The block takes one item at a time and accepts the next once the
// current one is done. A finished result waits in an output register; if
// the receiver still holds the previous result, the next tick stalls in its
// last step until that register frees.
// Reset sets the gains to their defaults, empties the path, puts the
// position at (-10, -10) and clears the PID state; the reset is synchronous.
module waypoint_pid_follower_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // point_x, point_y
    input  wire logic [1:0]  s_axis_tuser,   // opcode, first_point
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [151:0]     m_axis_tdata,   // pos_x, pos_y, heading, speed, accel,
                                             // point_index, zero fill
    output logic             m_axis_tlast,   // arrived
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    wpf_pkg::t_state r_state, n_state;

    logic [21:0] r_gain_p, r_gain_i, r_gain_d, r_step_lim, r_arrive;
    logic [17:0] r_turn_lim;

    logic [wpf_pkg::LEN_W-1:0] r_len, r_idx, nidx;
    logic signed [31:0] r_cur_x, r_cur_y, r_yaw, r_last_spd;
    logic [30:0]        r_last_err, r_err;
    logic [39:0]        r_sum;

    logic                             r_zero, r_flip;
    logic signed [wpf_pkg::ZW-1:0]    r_bear;
    logic [wpf_pkg::CORDIC_STEPS-1:0] r_dirs;
    logic signed [52:0]               r_prod;
    logic [44:0]                      r_sprod;
    logic signed [36:0]               r_deriv;
    logic signed [63:0]               r_acc;
    logic [2:0]                       r_k;
    logic signed [22:0]               r_step;
    logic signed [40:0]               r_mvp;
    logic signed [wpf_pkg::CW-1:0]    r_mx, r_my;

    logic                             r_out_valid, r_out_last;
    logic [wpf_pkg::OUT_W-1:0]        r_out_data;

    // handshake and control strobes
    logic in_acc, is_load, load_we, tick_go, upd_go, cfg_wr;
    logic [wpf_pkg::AW-1:0] waddr;
    logic [63:0] rdata;

    wpf_pkg::t_cor_cmd  cor_cmd;
    wpf_pkg::t_cor_stat cor_stat;
    logic signed [wpf_pkg::CW-1:0] cor_x0, cor_y0, cor_xo, cor_yo;
    logic signed [wpf_pkg::ZW-1:0] cor_z0, cor_zo;
    logic [wpf_pkg::CORDIC_STEPS-1:0] cor_dirs;

    logic signed [32:0] dx, dy;
    logic               zero_c, flip_c;
    logic signed [52:0] dist_q;
    logic [40:0]        sum_add;
    logic signed [31:0] diff;
    logic signed [40:0] term;
    logic [10:0]        chunk;
    logic [21:0]        gsel;
    logic signed [52:0] prod;
    logic signed [63:0] prod64;
    logic signed [47:0] sres;
    logic signed [22:0] slim;
    logic signed [39:0] ydiff, dyaw, tlim, vel, acc10;
    logic signed [31:0] nx, ny, nyaw;
    logic [17:0]        spd_o;
    logic [21:0]        acc_o;
    logic               arrive;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign is_load = s_axis_tuser[0];
    assign load_we = in_acc && is_load
                     && (s_axis_tuser[1] || r_len < wpf_pkg::LEN_W'(wpf_pkg::MAX_POINTS));
    assign waddr   = s_axis_tuser[1] ? '0 : r_len[wpf_pkg::AW-1:0];
    assign tick_go = in_acc && !is_load && (r_idx < r_len);
    assign upd_go  = (r_state == wpf_pkg::ST_UPD) && (!r_out_valid || m_axis_tready);

    wpf_ram #(
        .DEPTH (wpf_pkg::MAX_POINTS),
        .WIDTH (64)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (tick_go),
        .i_raddr (r_idx[wpf_pkg::AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        dx     = 33'(signed'(rdata[31:0])) - 33'(r_cur_x);
        dy     = 33'(signed'(rdata[63:32])) - 33'(r_cur_y);
        zero_c = (dx == '0) && (dy == '0);
        flip_c = !zero_c && dx[32];
        if (r_state == wpf_pkg::ST_MVS) begin
            cor_x0 = wpf_pkg::CW'(r_mvp >>> 16);
            cor_y0 = '0;
            cor_z0 = '0;
        end else if (flip_c) begin
            cor_x0 = -wpf_pkg::CW'(dx);
            cor_y0 = -wpf_pkg::CW'(dy);
            cor_z0 = dy[32] ? -wpf_pkg::PI_Q : wpf_pkg::PI_Q;
        end else begin
            cor_x0 = wpf_pkg::CW'(dx);
            cor_y0 = wpf_pkg::CW'(dy);
            cor_z0 = '0;
        end
        cor_cmd.start  = ((r_state == wpf_pkg::ST_FETCH) && !zero_c)
                         || ((r_state == wpf_pkg::ST_MVS) && !r_zero);
        cor_cmd.rotate = (r_state == wpf_pkg::ST_MVS);
        cor_cmd.dirs   = r_dirs;
    end

    wpf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cor_cmd),
        .i_x     (cor_x0),
        .i_y     (cor_y0),
        .i_z     (cor_z0),
        .o_stat  (cor_stat),
        .o_x     (cor_xo),
        .o_y     (cor_yo),
        .o_z     (cor_zo),
        .o_dirs  (cor_dirs)
    );

    // next state
    always_comb begin
        n_state       = r_state;
        s_axis_tready = (r_state == wpf_pkg::ST_IDLE);
        case (r_state)
            wpf_pkg::ST_IDLE:  if (tick_go) n_state = wpf_pkg::ST_FETCH;
            wpf_pkg::ST_FETCH: n_state = zero_c ? wpf_pkg::ST_ERR : wpf_pkg::ST_VEC;
            wpf_pkg::ST_VEC:   if (cor_stat.done) n_state = wpf_pkg::ST_DIST;
            wpf_pkg::ST_DIST:  n_state = wpf_pkg::ST_ERR;
            wpf_pkg::ST_ERR:   n_state = wpf_pkg::ST_SUM;
            wpf_pkg::ST_SUM:   n_state = wpf_pkg::ST_MAC;
            wpf_pkg::ST_MAC:   if (r_k == 3'd5) n_state = wpf_pkg::ST_STEP;
            wpf_pkg::ST_STEP:  n_state = wpf_pkg::ST_MV;
            wpf_pkg::ST_MV:    n_state = wpf_pkg::ST_MVS;
            wpf_pkg::ST_MVS:   n_state = r_zero ? wpf_pkg::ST_UPD : wpf_pkg::ST_ROT;
            wpf_pkg::ST_ROT:   if (cor_stat.done) n_state = wpf_pkg::ST_UPD;
            wpf_pkg::ST_UPD:   if (upd_go) n_state = wpf_pkg::ST_IDLE;
            default:           n_state = wpf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath arithmetic
    always_comb begin
        dist_q  = (r_prod + 53'sd32768) >>> 16;
        sum_add = 41'(r_sum) + 41'(r_sprod[44:16]);
        diff    = signed'({1'b0, r_err}) - signed'({1'b0, r_last_err});
        case (r_k[2:1])
            2'd0:    term = signed'({10'b0, r_err});
            2'd1:    term = signed'({1'b0, r_sum});
            2'd2:    term = 41'(r_deriv);
            default: term = '0;
        endcase
        case (r_k[2:1])
            2'd0:    gsel = r_gain_p;
            2'd1:    gsel = r_gain_i;
            2'd2:    gsel = r_gain_d;
            default: gsel = '0;
        endcase
        chunk  = r_k[0] ? gsel[21:11] : gsel[10:0];
        prod   = term * signed'({1'b0, chunk});
        prod64 = r_k[0] ? (64'(prod) <<< 11) : 64'(prod);
        sres   = 48'(r_acc >>> 16);
        slim   = signed'({1'b0, r_step_lim});

        nx    = wpf_pkg::sat32(40'(r_cur_x) + 40'(r_mx));
        ny    = wpf_pkg::sat32(40'(r_cur_y) + 40'(r_my));
        ydiff = 40'(r_bear) - 40'(r_yaw);
        tlim  = 40'(signed'({1'b0, r_turn_lim}));
        if (ydiff > tlim)
            dyaw = tlim;
        else if (ydiff < -tlim)
            dyaw = -tlim;
        else
            dyaw = ydiff;
        nyaw  = wpf_pkg::sat32(40'(r_yaw) + dyaw);
        vel   = 40'(r_step) * 40'sd10;
        acc10 = (vel - 40'(r_last_spd)) * 40'sd10;
        if (vel > 40'sd131071)
            spd_o = 18'h1FFFF;
        else if (vel < -40'sd131072)
            spd_o = 18'h20000;
        else
            spd_o = vel[17:0];
        if (acc10 > 40'sd2097151)
            acc_o = 22'h1FFFFF;
        else if (acc10 < -40'sd2097152)
            acc_o = 22'h200000;
        else
            acc_o = acc10[21:0];
        arrive = {1'b0, r_err} < {10'b0, r_arrive};
        nidx   = arrive ? r_idx + 1'b1 : r_idx;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wpf_pkg::ST_FETCH: begin
                r_zero <= zero_c;
                r_flip <= flip_c;
                r_bear <= '0;
                r_err  <= '0;
            end
            wpf_pkg::ST_VEC: begin
                if (cor_stat.done) begin
                    r_bear <= cor_zo;
                    r_dirs <= cor_dirs;
                    r_prod <= cor_xo * wpf_pkg::INV_GAIN;
                end
            end
            wpf_pkg::ST_DIST: begin
                if (dist_q < 0)
                    r_err <= '0;
                else if (dist_q > 53'sd2147483647)
                    r_err <= '1;
                else
                    r_err <= dist_q[30:0];
            end
            wpf_pkg::ST_ERR: begin
                r_sprod <= 45'(r_err * wpf_pkg::DT_Q) + 45'(wpf_pkg::HALF_Q);
            end
            wpf_pkg::ST_SUM: begin
                r_deriv <= 37'(diff) * 37'sd10;
                r_acc   <= 64'(wpf_pkg::HALF_Q);
                r_k     <= '0;
            end
            wpf_pkg::ST_MAC: begin
                r_acc <= r_acc + prod64;
                r_k   <= r_k + 1'b1;
            end
            wpf_pkg::ST_STEP: begin
                if (sres > 48'(slim))
                    r_step <= slim;
                else if (sres < -48'(slim))
                    r_step <= -slim;
                else
                    r_step <= sres[22:0];
            end
            wpf_pkg::ST_MV: begin
                r_mvp <= 41'(r_step) * 41'(wpf_pkg::INV_GAIN) + 41'(wpf_pkg::HALF_Q);
            end
            wpf_pkg::ST_MVS: begin
                r_mx <= wpf_pkg::CW'(r_step);
                r_my <= '0;
            end
            wpf_pkg::ST_ROT: begin
                if (cor_stat.done) begin
                    r_mx <= r_flip ? -cor_xo : cor_xo;
                    r_my <= r_flip ? -cor_yo : cor_yo;
                end
            end
            default: ;
        endcase
        if (upd_go) begin
            r_out_data <= {7'b0, 9'(nidx), acc_o, spd_o, nyaw, ny, nx};
            r_out_last <= (nidx >= r_len);
        end
    end

    // controller state held across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_idx       <= '0;
            r_cur_x     <= -32'sd655360;
            r_cur_y     <= -32'sd655360;
            r_yaw       <= '0;
            r_last_err  <= '0;
            r_sum       <= '0;
            r_last_spd  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc && is_load) begin
                if (s_axis_tuser[1]) begin
                    r_idx <= '0;
                    r_len <= wpf_pkg::LEN_W'(1);
                end else if (load_we) begin
                    r_len <= r_len + 1'b1;
                end
            end
            if (r_state == wpf_pkg::ST_SUM) begin
                r_sum <= (sum_add > 41'(wpf_pkg::SUM_MAX)) ? wpf_pkg::SUM_MAX
                                                           : sum_add[39:0];
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (upd_go) begin
                r_cur_x     <= nx;
                r_cur_y     <= ny;
                r_yaw       <= nyaw;
                r_last_err  <= r_err;
                r_last_spd  <= vel[31:0];
                r_idx       <= nidx;
                r_out_valid <= 1'b1;
                if (arrive) begin
                    r_sum <= '0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= 22'd65536;
            r_gain_i   <= 22'd6554;
            r_gain_d   <= 22'd3277;
            r_step_lim <= 22'd6554;
            r_turn_lim <= 18'd6554;
            r_arrive   <= 22'd6554;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                wpf_pkg::REG_GAIN_P:   r_gain_p   <= pwdata[21:0];
                wpf_pkg::REG_GAIN_I:   r_gain_i   <= pwdata[21:0];
                wpf_pkg::REG_GAIN_D:   r_gain_d   <= pwdata[21:0];
                wpf_pkg::REG_STEP_LIM: r_step_lim <= pwdata[21:0];
                wpf_pkg::REG_TURN_LIM: r_turn_lim <= pwdata[17:0];
                wpf_pkg::REG_ARRIVE:   r_arrive   <= pwdata[21:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            wpf_pkg::REG_GAIN_P:   prdata = {10'b0, r_gain_p};
            wpf_pkg::REG_GAIN_I:   prdata = {10'b0, r_gain_i};
            wpf_pkg::REG_GAIN_D:   prdata = {10'b0, r_gain_d};
            wpf_pkg::REG_STEP_LIM: prdata = {10'b0, r_step_lim};
            wpf_pkg::REG_TURN_LIM: prdata = {14'b0, r_turn_lim};
            wpf_pkg::REG_ARRIVE:   prdata = {10'b0, r_arrive};
            default:               prdata = '0;
        endcase
    end

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= wpf_pkg::LEN_W'(wpf_pkg::MAX_POINTS))
        else $error("path length past store capacity");

    a_idx_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_len)
        else $error("target index beyond path length");

    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == wpf_pkg::ST_UPD))
        else $error("result item loaded outside update step");

    a_cordic_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_cmd.start |-> !cor_stat.busy)
        else $error("CORDIC started while busy");

endmodule
`default_nettype wire

FILE: verif/tb_waypoint_pid_follower_unit.sv
`default_nettype none
module tb_waypoint_pid_follower_unit;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] hdg;
        logic [17:0]        spd;
        logic [21:0]        acc;
        logic [8:0]         idx;
        logic               arr;
    } t_nav_state;

    typedef struct {
        bit          load;
        bit          first;
        logic [31:0] px;
        logic [31:0] py;
        bit          no_result;
    } t_path_row;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid, m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic m_axis_tlast;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;

    waypoint_pid_follower_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // predictor copy of the block
    logic signed [31:0] wp_x [wpf_pkg::MAX_POINTS];
    logic signed [31:0] wp_y [wpf_pkg::MAX_POINTS];
    int unsigned wp_len, wp_idx;
    longint pos_x, pos_y, yaw, prev_err, err_sum, prev_vel;
    longint g_p, g_i, g_d, step_lim, turn_lim, arrive_rad;

    t_nav_state pending_states[$];
    int errors, items_sent, loads_sent, ticks_sent, results_seen, arrivals;
    bit quiet;
    int idle_cnt;

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_step(int i);
        longint tab [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1};
        return i < 17 ? tab[i] : 0;
    endfunction

    task automatic follow_tick();
        longint dx, dy, x, y, z, xs, ys, dist_q, err, deriv, acc, step;
        longint mx, my, vel, acc10, dyaw;
        bit [wpf_pkg::CORDIC_STEPS-1:0] dirs;
        bit flip, zero;
        t_nav_state r;
        if (wp_len == 0 || wp_idx >= wp_len) return;
        dx = longint'(wp_x[wp_idx]) - pos_x;
        dy = longint'(wp_y[wp_idx]) - pos_y;
        zero = (dx == 0 && dy == 0);
        flip = 0;
        dirs = '0;
        x = dx; y = dy; z = 0;
        if (!zero && dx < 0) begin
            flip = 1;
            x = -dx; y = -dy;
            z = dy >= 0 ? 205887 : -205887;
        end
        if (zero) begin
            dist_q = 0;
        end else begin
            for (int i = 0; i < wpf_pkg::CORDIC_STEPS; i++) begin
                xs = x >>> i; ys = y >>> i;
                if (y >= 0) begin
                    dirs[i] = 1'b1;
                    x += ys; y -= xs; z += atan_step(i);
                end else begin
                    x -= ys; y += xs; z -= atan_step(i);
                end
            end
            dist_q = (x * 39797 + 32768) >>> 16;
        end
        err = clampl(dist_q, 0, 64'sd2147483647);
        err_sum = clampl(err_sum + ((err * 6554 + 32768) >>> 16), 0, 64'sh7F_FFFF_FFFF);
        deriv = (err - prev_err) * 10;
        acc = g_p * err + g_i * err_sum + g_d * deriv + 32768;
        step = clampl(acc >>> 16, -step_lim, step_lim);
        if (zero) begin
            mx = step; my = 0;
        end else begin
            mx = (step * 39797 + 32768) >>> 16;
            my = 0;
            for (int i = 0; i < wpf_pkg::CORDIC_STEPS; i++) begin
                xs = mx >>> i; ys = my >>> i;
                if (dirs[i]) begin
                    mx -= ys; my += xs;
                end else begin
                    mx += ys; my -= xs;
                end
            end
            if (flip) begin
                mx = -mx; my = -my;
            end
        end
        pos_x = clampl(pos_x + mx, -64'sd2147483648, 64'sd2147483647);
        pos_y = clampl(pos_y + my, -64'sd2147483648, 64'sd2147483647);
        dyaw = clampl(z - yaw, -turn_lim, turn_lim);
        yaw = clampl(yaw + dyaw, -64'sd2147483648, 64'sd2147483647);
        vel = step * 10;
        acc10 = (vel - prev_vel) * 10;
        if (err < arrive_rad) begin
            wp_idx++;
            err_sum = 0;
        end
        prev_err = err;
        prev_vel = vel;
        r.px = pos_x[31:0];
        r.py = pos_y[31:0];
        r.hdg = yaw[31:0];
        r.spd = 18'(clampl(vel, -131072, 131071));
        r.acc = 22'(clampl(acc10, -2097152, 2097151));
        r.idx = wp_idx[8:0];
        r.arr = wp_idx >= wp_len;
        pending_states.push_back(r);
    endtask

    task automatic apply_item(bit load, bit first, logic [31:0] px, logic [31:0] py);
        if (load) begin
            if (first) begin
                wp_len = 0;
                wp_idx = 0;
            end
            if (wp_len < wpf_pkg::MAX_POINTS) begin
                wp_x[wp_len] = px;
                wp_y[wp_len] = py;
                wp_len++;
            end
        end else begin
            follow_tick();
        end
    endtask

    // one item through the input handshake; predictor runs on acceptance
    task automatic send_item(bit load, bit first, logic [31:0] px, logic [31:0] py);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {first, load};
        s_axis_tdata <= {py, px};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        apply_item(load, first, px, py);
        items_sent++;
        if (load) loads_sent++;
        else ticks_sent++;
    endtask

    task automatic drain(int settle);
        s_axis_tvalid <= 1'b0;
        while (pending_states.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic reg_write(wpf_pkg::t_reg r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(r) << 2; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            wpf_pkg::REG_GAIN_P:   g_p = v[21:0];
            wpf_pkg::REG_GAIN_I:   g_i = v[21:0];
            wpf_pkg::REG_GAIN_D:   g_d = v[21:0];
            wpf_pkg::REG_STEP_LIM: step_lim = v[21:0];
            wpf_pkg::REG_TURN_LIM: turn_lim = v[17:0];
            wpf_pkg::REG_ARRIVE:   arrive_rad = v[21:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [21:0] p, logic [21:0] i, logic [21:0] d,
                             logic [21:0] sl, logic [17:0] tl, logic [21:0] ar);
        // junk above each register's width must be dropped
        reg_write(wpf_pkg::REG_GAIN_P, {10'($urandom_range(0, 1023)), p});
        reg_write(wpf_pkg::REG_GAIN_I, {10'($urandom_range(0, 1023)), i});
        reg_write(wpf_pkg::REG_GAIN_D, {10'($urandom_range(0, 1023)), d});
        reg_write(wpf_pkg::REG_STEP_LIM, {10'($urandom_range(0, 1023)), sl});
        reg_write(wpf_pkg::REG_TURN_LIM, {14'($urandom_range(0, 16383)), tl});
        reg_write(wpf_pkg::REG_ARRIVE, {10'($urandom_range(0, 1023)), ar});
    endtask

    function automatic logic [31:0] near_point(longint base);
        longint off;
        case ($urandom_range(0, 4))
            0: off = $signed(32'($urandom_range(0, 131071))) - 65536;
            1: off = $signed(32'($urandom_range(0, 2097151))) - 1048576;
            2: off = $signed(32'($urandom_range(0, 33554431))) - 16777216;
            3: off = 0;
            default: return $urandom;
        endcase
        return 32'(base + off);
    endfunction

    // result checking and receiver stalls
    int hold;
    always @(posedge i_clk) begin
        t_nav_state e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tlast) arrivals++;
            if (pending_states.size() == 0) begin
                $error("unexpected result item: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                e = pending_states.pop_front();
                if (m_axis_tdata[31:0] !== e.px) begin
                    $error("pos_x: expected %0d, got %0d", e.px, $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.py) begin
                    $error("pos_y: expected %0d, got %0d", e.py, $signed(m_axis_tdata[63:32]));
                    errors++;
                end
                if (m_axis_tdata[95:64] !== e.hdg) begin
                    $error("heading: expected %0d, got %0d", e.hdg,
                           $signed(m_axis_tdata[95:64]));
                    errors++;
                end
                if (m_axis_tdata[113:96] !== e.spd) begin
                    $error("speed: expected %h, got %h", e.spd, m_axis_tdata[113:96]);
                    errors++;
                end
                if (m_axis_tdata[135:114] !== e.acc) begin
                    $error("accel: expected %h, got %h", e.acc, m_axis_tdata[135:114]);
                    errors++;
                end
                if (m_axis_tdata[144:136] !== e.idx) begin
                    $error("point_index: expected %0d, got %0d", e.idx, m_axis_tdata[144:136]);
                    errors++;
                end
                if (m_axis_tlast !== e.arr) begin
                    $error("arrived: expected %0b, got %0b", e.arr, m_axis_tlast);
                    errors++;
                end
            end
            hold <= quiet ? 0 : $urandom_range(0, 9);
            if (!quiet) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (hold <= 1) m_axis_tready <= 1'b1;
            hold <= hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= 5000) begin
            $display("tb_waypoint_pid_follower_unit: FAIL");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    t_path_row dir_rows [] = '{
        '{0, 0, 32'h0, 32'h0, 1},                   // tick on empty path
        '{1, 1, -32'sd655360, -32'sd655360, 0},     // zero offset
        '{0, 0, 32'h0, 32'h0, 0},
        '{1, 0, -32'sd458752, -32'sd655360, 0},
        '{0, 0, 32'h0, 32'h0, 0},
        '{0, 0, 32'h0, 32'h0, 0},
        '{0, 0, 32'h0, 32'h0, 0},                   // tick, path not finished yet
        '{1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
        '{0, 0, 32'h0, 32'h0, 0},
        '{1, 1, 32'h8000_0000, 32'h8000_0000, 0},
        '{0, 0, 32'h0, 32'h0, 0},
        '{1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0},
        '{0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0},   // first flag on a tick
        '{1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0},
        '{0, 0, 32'h0, 32'h0, 0},
        '{1, 1, -32'sd800000, -32'sd700000, 0},     // behind, below
        '{0, 0, 32'h0, 32'h0, 0},
        '{1, 1, -32'sd800000, -32'sd0, 0},
        '{0, 0, 32'h0, 32'h0, 0},
        '{0, 0, 32'h0, 32'h0, 0}
    };

    initial begin
        int n_before, n_pts, n_ticks, ph;
        logic [31:0] px, py;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        errors = 0; items_sent = 0; loads_sent = 0; ticks_sent = 0;
        results_seen = 0; arrivals = 0; quiet = 0;
        foreach (wp_x[k]) begin
            wp_x[k] = 0; wp_y[k] = 0;
        end
        wp_len = 0; wp_idx = 0;
        pos_x = -655360; pos_y = -655360; yaw = 0;
        prev_err = 0; err_sum = 0; prev_vel = 0;
        g_p = 65536; g_i = 6554; g_d = 3277;
        step_lim = 6554; turn_lim = 6554; arrive_rad = 6554;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // out-of-range register index must change nothing
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'd24; pwdata <= '1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;

        foreach (dir_rows[k]) begin
            n_before = pending_states.size();
            if (k == 7) begin
                drain(60);
                set_gains(22'd65536, 22'd6554, 22'd3277, 22'h3FFFFF, 18'd205887, 22'h3FFFFF);
            end
            send_item(dir_rows[k].load, dir_rows[k].first, dir_rows[k].px, dir_rows[k].py);
            if (dir_rows[k].no_result && pending_states.size() != n_before) begin
                $error("row %0d: no result should follow", k);
                errors++;
            end
        end

        ph = 0;
        while (items_sent < 1230) begin
            drain(60);
            case (ph % 6)
                0: set_gains(22'd65536, 22'd6554, 22'd3277, 22'd6554, 18'd6554, 22'd6554);
                1: set_gains('1, '1, '1, '1, 18'd205887, '1);
                2: set_gains('0, '0, '0, '0, '0, '0);
                3: set_gains(22'd65536, 22'd0, 22'd0, 22'h3FFFFF, 18'd205887, 22'd65536);
                4: set_gains(22'd49152, 22'd655, 22'd1000, 22'd200000, 18'd30000, 22'd32768);
                default: set_gains(22'($urandom), 22'($urandom), 22'($urandom),
                                   22'($urandom), 18'($urandom_range(0, 205887)),
                                   22'($urandom));
            endcase
            quiet = (ph % 4 == 3);
            repeat (3) begin
                // full store case once
                n_pts = (ph == 4) ? 260 : $urandom_range(1, 8);
                send_item(1'b1, 1'b1, near_point(pos_x), near_point(pos_y));
                for (int k = 1; k < n_pts; k++)
                    send_item(1'b1, 1'b0, near_point(pos_x), near_point(pos_y));
                n_ticks = (ph == 4) ? 30 : $urandom_range(n_pts, 3 * n_pts + 6);
                for (int k = 0; k < n_ticks; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        px = $urandom; py = $urandom;
                        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  px, py);
                    end else begin
                        send_item(1'b0, 1'($urandom_range(0, 1)), $urandom, $urandom);
                    end
                end
            end
            ph++;
        end

        drain(100);
        quiet = 0;
        $display("covered %0d items (%0d loads, %0d ticks) over %0d gain settings,",
                 items_sent, loads_sent, ticks_sent, ph + 2);
        $display("checked %0d result items, %0d of them ending a path", results_seen, arrivals);
        if (errors == 0)
            $display("tb_waypoint_pid_follower_unit: PASS");
        else
            $display("tb_waypoint_pid_follower_unit: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
